// File: hw/rtl/frame_min_step_quantizer_defines.svh
// Assertion macros shared by the quantizer RTL.
`ifndef FRAME_MIN_STEP_QUANTIZER_DEFINES_SVH
`define FRAME_MIN_STEP_QUANTIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fmsq_pkg.sv
`default_nettype none

package fmsq_pkg;

    // Field widths.
    localparam int TEMP_W   = 23;
    localparam int FRAME_W  = 32;
    localparam int LEVEL_W  = 8;
    localparam int ORIGIN_W = 16;
    localparam int STEP_W   = 16;
    localparam int SEQ_W    = 32;

    // Origin expressed in 0.0001 degC units.
    localparam int OT_W = 24;

    localparam int GRID_PIXELS_DEF = 64;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    localparam int CENTI_SCALE = 100;
    localparam int LEVEL_MAX   = 255;
    localparam int STEP_ROUND  = LEVEL_MAX - 1;
    localparam int STEP_MIN    = 1;
    localparam int STEP_MAX    = 65535;
    localparam int ORIGIN_MAX  = 2 ** (ORIGIN_W - 1) - 1;
    localparam int ORIGIN_MIN  = -(2 ** (ORIGIN_W - 1));

    // Reciprocals for the constant divisions of the front. Each one is the
    // rounded-up value of 2**SHIFT / divisor, which gives the exact floor
    // quotient for every numerator below 2**23.
    localparam int RECIP_W     = 24;
    localparam int CENTI_RECIP = 10737419;
    localparam int CENTI_SHIFT = 30;
    localparam int LEVEL_RECIP = 8421505;
    localparam int LEVEL_SHIFT = 31;

    // Quotient bits resolved per divider cycle.
    localparam int DIV_STEPS = 2;

    // Two frames in flight, one per pixel store bank.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [ORIGIN_W-1:0] origin_centi;
        logic signed [OT_W-1:0]     origin_temp;
        logic [STEP_W-1:0]          step_size;
        logic [FRAME_W-1:0]         frame_id;
        logic [SEQ_W-1:0]           sequence_res;
        logic                       bank;
    } frame_job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/fmsq_ram.sv
`default_nettype none

module fmsq_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fmsq_div.sv
`default_nettype none

// Restoring divider with a bounded quotient, STEPS quotient bits per cycle.
// ovf flags a quotient that does not fit in QUO_W bits.
module fmsq_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8,
    parameter int QUO_W = 16,
    parameter int STEPS = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [QUO_W-1:0] quo,
    output logic                  ovf
);

    localparam int REM_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int ROUNDS = QUO_W / STEPS;
    localparam int CNT_W  = $clog2(ROUNDS + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic             ovf_reg, ovf_next;

    logic [REM_W-1:0] r_tmp, d_tmp;
    logic [QUO_W-1:0] q_tmp;

    always_comb
    begin
        r_tmp = rem_reg;
        d_tmp = dsh_reg;
        q_tmp = quo_reg;
        for (int s = 0; s < STEPS; s++)
        begin
            if (r_tmp >= d_tmp)
            begin
                r_tmp = r_tmp - d_tmp;
                q_tmp = {q_tmp[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q_tmp = {q_tmp[QUO_W-2:0], 1'b0};
            end
            d_tmp = d_tmp >> 1;
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(ROUNDS);
            rem_next = REM_W'(num);
            dsh_next = REM_W'(den) << (QUO_W - 1);
            quo_next = '0;
            ovf_next = REM_W'(num) >= (REM_W'(den) << QUO_W);
        end
        else if (run_reg)
        begin
            rem_next = r_tmp;
            dsh_next = d_tmp;
            quo_next = q_tmp;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fmsq_front.sv
`default_nettype none

// Loads pixels into the current store bank, tracks the frame extremes and
// works out origin and step for each completed frame. Both divisions are by
// a constant and are done as a reciprocal multiplication whose quotient is
// registered before it is used.
module fmsq_front #(
    parameter int GRID_PIXELS = fmsq_pkg::GRID_PIXELS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [fmsq_pkg::TEMP_W-1:0]   temperature,
    input  wire logic [fmsq_pkg::FRAME_W-1:0]         frame_number,
    input  wire fmsq_pkg::queue_status_t              qstat,
    output logic                                      push,
    output fmsq_pkg::frame_job_t                      job,
    output logic                                      ram_we,
    output logic [$clog2(GRID_PIXELS):0]              ram_waddr,
    output logic [fmsq_pkg::TEMP_W-1:0]               ram_wdata
);

    localparam int IDX_W  = $clog2(GRID_PIXELS);
    localparam int NUM_W  = fmsq_pkg::TEMP_W + 1;
    localparam int QUO_W  = fmsq_pkg::STEP_W + 1;
    localparam int PROD_W = NUM_W + fmsq_pkg::RECIP_W;
    localparam int OCW    = fmsq_pkg::STEP_W + 2;
    localparam int OT_W   = fmsq_pkg::OT_W;
    localparam int SPAN_W = fmsq_pkg::OT_W + 1;

    typedef enum logic [4:0] {
        F_LOAD  = 5'b00001,
        F_DIVO  = 5'b00010,
        F_WAITO = 5'b00100,
        F_DIVS  = 5'b01000,
        F_WAITS = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [IDX_W-1:0]                       count_reg, count_next;
    logic                                   bank_reg, bank_next;
    logic signed [fmsq_pkg::TEMP_W-1:0]     min_reg, min_next;
    logic signed [fmsq_pkg::TEMP_W-1:0]     max_reg, max_next;
    logic [fmsq_pkg::FRAME_W-1:0]           held_frame_reg, held_frame_next;
    logic [fmsq_pkg::SEQ_W-1:0]             seq_reg, seq_next;
    logic signed [fmsq_pkg::ORIGIN_W-1:0]   origin_reg, origin_next;
    logic signed [OT_W-1:0]                 ot_reg, ot_next;
    logic [QUO_W-1:0]                       quo_reg, quo_next;

    logic                         accept;
    logic                         frame_done;
    logic [PROD_W-1:0]            origin_prod;
    logic [PROD_W-1:0]            step_prod;

    logic                                 min_neg;
    logic signed [NUM_W-1:0]              min_ext;
    logic [NUM_W-1:0]                     min_mag, min_num;
    logic signed [OCW-1:0]                oc_mag, oc_wide;
    logic signed [fmsq_pkg::ORIGIN_W-1:0] origin_sat;
    logic signed [OT_W-1:0]               origin_wide, ot_calc;
    logic signed [SPAN_W-1:0]             span;
    logic                                 span_pos;
    logic [NUM_W-1:0]                     step_num;
    logic [fmsq_pkg::STEP_W-1:0]          step_clamped, step_val;

    assign busy   = (state_reg != F_LOAD) || qstat.full;
    assign accept = start && !busy;

    assign ram_we    = accept;
    assign ram_waddr = {bank_reg, count_reg};
    assign ram_wdata = temperature;

    // Origin division works on the magnitude; a negative minimum rounds
    // its magnitude up so that the result is the floor.
    assign min_neg = min_reg[fmsq_pkg::TEMP_W-1];
    assign min_ext = NUM_W'(min_reg);
    assign min_mag = min_neg ? unsigned'(-min_ext) : unsigned'(min_ext);
    assign min_num = min_neg ? min_mag + NUM_W'(fmsq_pkg::CENTI_SCALE - 1) : min_mag;

    assign origin_prod = PROD_W'(min_num) * PROD_W'(fmsq_pkg::CENTI_RECIP);

    assign oc_mag  = signed'(OCW'(quo_reg));
    assign oc_wide = min_neg ? -oc_mag : oc_mag;

    always_comb
    begin
        if (oc_wide > OCW'(fmsq_pkg::ORIGIN_MAX))
        begin
            origin_sat = fmsq_pkg::ORIGIN_W'(fmsq_pkg::ORIGIN_MAX);
        end
        else if (oc_wide < OCW'(fmsq_pkg::ORIGIN_MIN))
        begin
            origin_sat = fmsq_pkg::ORIGIN_W'(fmsq_pkg::ORIGIN_MIN);
        end
        else
        begin
            origin_sat = oc_wide[fmsq_pkg::ORIGIN_W-1:0];
        end
    end

    assign origin_wide = OT_W'(origin_sat);
    assign ot_calc     = origin_wide * OT_W'(fmsq_pkg::CENTI_SCALE);

    assign span      = SPAN_W'(max_reg) - SPAN_W'(ot_reg);
    assign span_pos  = !span[SPAN_W-1] && (span != '0);
    assign step_num  = NUM_W'(span) + NUM_W'(fmsq_pkg::STEP_ROUND);
    assign step_prod = PROD_W'(step_num) * PROD_W'(fmsq_pkg::LEVEL_RECIP);

    always_comb
    begin
        if (quo_reg > QUO_W'(fmsq_pkg::STEP_MAX))
        begin
            step_clamped = fmsq_pkg::STEP_W'(fmsq_pkg::STEP_MAX);
        end
        else if (quo_reg == '0)
        begin
            step_clamped = fmsq_pkg::STEP_W'(fmsq_pkg::STEP_MIN);
        end
        else
        begin
            step_clamped = quo_reg[fmsq_pkg::STEP_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        bank_next       = bank_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        held_frame_next = held_frame_reg;
        seq_next        = seq_reg;
        origin_next     = origin_reg;
        ot_next         = ot_reg;
        quo_next        = quo_reg;
        push            = 1'b0;
        frame_done      = 1'b0;
        step_val        = fmsq_pkg::STEP_W'(fmsq_pkg::STEP_MIN);

        case (state_reg)
            F_LOAD:
            begin
                if (accept)
                begin
                    if (temperature < min_reg)
                    begin
                        min_next = temperature;
                    end
                    if (temperature > max_reg)
                    begin
                        max_next = temperature;
                    end
                    held_frame_next = frame_number;
                    if (count_reg == IDX_W'(GRID_PIXELS - 1))
                    begin
                        count_next = '0;
                        state_next = F_DIVO;
                    end
                    else
                    begin
                        count_next = count_reg + IDX_W'(1);
                    end
                end
            end
            F_DIVO:
            begin
                // Magnitude of the origin in centi-degrees.
                quo_next   = origin_prod[fmsq_pkg::CENTI_SHIFT +: QUO_W];
                state_next = F_WAITO;
            end
            F_WAITO:
            begin
                origin_next = origin_sat;
                ot_next     = ot_calc;
                state_next  = F_DIVS;
            end
            F_DIVS:
            begin
                if (span_pos)
                begin
                    quo_next   = step_prod[fmsq_pkg::LEVEL_SHIFT +: QUO_W];
                    state_next = F_WAITS;
                end
                else
                begin
                    push       = 1'b1;
                    frame_done = 1'b1;
                end
            end
            F_WAITS:
            begin
                push       = 1'b1;
                frame_done = 1'b1;
                step_val   = step_clamped;
            end
            default:
            begin
                state_next = F_LOAD;
            end
        endcase

        if (frame_done)
        begin
            min_next   = fmsq_pkg::TEMP_MAX;
            max_next   = fmsq_pkg::TEMP_MIN;
            seq_next   = seq_reg + fmsq_pkg::SEQ_W'(1);
            bank_next  = !bank_reg;
            state_next = F_LOAD;
        end
    end

    always_comb
    begin
        job.origin_centi = origin_reg;
        job.origin_temp  = ot_reg;
        job.step_size    = step_val;
        job.frame_id     = held_frame_reg;
        job.sequence_res = seq_reg;
        job.bank         = bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_LOAD;
            count_reg      <= '0;
            bank_reg       <= 1'b0;
            min_reg        <= fmsq_pkg::TEMP_MAX;
            max_reg        <= fmsq_pkg::TEMP_MIN;
            held_frame_reg <= '0;
            seq_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            bank_reg       <= bank_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            held_frame_reg <= held_frame_next;
            seq_reg        <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        origin_reg <= origin_next;
        ot_reg     <= ot_next;
        quo_reg    <= quo_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/fmsq_queue.sv
`default_nettype none

// Short queue of finished frame descriptors between front and back.
module fmsq_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire fmsq_pkg::frame_job_t push_job,
    input  wire logic                 pop,
    output fmsq_pkg::frame_job_t      head,
    output fmsq_pkg::queue_status_t   status
);

    localparam int DEPTH = fmsq_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmsq_pkg::frame_job_t entries_reg [DEPTH];

    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wptr_reg] <= push_job;
        end
    end

    assign head         = entries_reg[rptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// File: hw/rtl/fmsq_back.sv
`default_nettype none

// Replays the stored pixels of the frame at the head of the queue and
// quantizes each pixel at or above the origin with an iterative divider.
module fmsq_back #(
    parameter int GRID_PIXELS = fmsq_pkg::GRID_PIXELS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fmsq_pkg::queue_status_t             qstat,
    input  wire fmsq_pkg::frame_job_t                job,
    output logic                                     pop,
    output logic [$clog2(GRID_PIXELS):0]             ram_raddr,
    input  wire logic [fmsq_pkg::TEMP_W-1:0]         ram_rdata,
    output logic                                     valid,
    output logic [fmsq_pkg::LEVEL_W-1:0]             level,
    output logic signed [fmsq_pkg::ORIGIN_W-1:0]     origin_centi,
    output logic [fmsq_pkg::STEP_W-1:0]              step_size,
    output logic [fmsq_pkg::FRAME_W-1:0]             frame_id,
    output logic [fmsq_pkg::SEQ_W-1:0]               sequence_res,
    output logic                                     last
);

    localparam int IDX_W  = $clog2(GRID_PIXELS);
    localparam int NUM_W  = fmsq_pkg::TEMP_W + 1;
    localparam int DEN_W  = fmsq_pkg::STEP_W + 1;
    localparam int DIFF_W = fmsq_pkg::OT_W + 1;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_READ  = 4'b0010,
        B_START = 4'b0100,
        B_WAIT  = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             cur_last_reg, cur_last_next;

    logic                                 valid_reg, valid_next;
    logic [fmsq_pkg::LEVEL_W-1:0]         level_reg;
    logic signed [fmsq_pkg::ORIGIN_W-1:0] origin_reg;
    logic [fmsq_pkg::STEP_W-1:0]          step_reg;
    logic [fmsq_pkg::FRAME_W-1:0]         frame_reg;
    logic [fmsq_pkg::SEQ_W-1:0]           seq_reg;
    logic                                 last_reg;

    logic                         emit, emit_last;
    logic [fmsq_pkg::LEVEL_W-1:0] emit_level;
    logic                         is_last;
    logic signed [DIFF_W-1:0]     diff;
    logic                         div_start, div_done, div_ovf;
    logic [NUM_W-1:0]             div_num;
    logic [DEN_W-1:0]             div_den;
    logic [fmsq_pkg::LEVEL_W-1:0] div_quo;

    assign ram_raddr = {job.bank, idx_reg};
    assign is_last   = (idx_reg == IDX_W'(GRID_PIXELS - 1));

    // Rounding half up: (2d + step) / (2 step).
    assign diff    = DIFF_W'(signed'(ram_rdata)) - DIFF_W'(signed'(job.origin_temp));
    assign div_num = {diff[NUM_W-2:0], 1'b0} + NUM_W'(job.step_size);
    assign div_den = {job.step_size, 1'b0};

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cur_last_next = cur_last_reg;
        emit          = 1'b0;
        emit_last     = 1'b0;
        emit_level    = '0;
        pop           = 1'b0;
        div_start     = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_START;
            end
            B_START:
            begin
                idx_next      = is_last ? '0 : idx_reg + IDX_W'(1);
                cur_last_next = is_last;
                if (diff[DIFF_W-1])
                begin
                    // A pixel below the origin sits at level zero.
                    emit       = 1'b1;
                    emit_last  = is_last;
                    pop        = is_last;
                    state_next = is_last ? B_IDLE : B_READ;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = B_WAIT;
                end
            end
            B_WAIT:
            begin
                if (div_done)
                begin
                    emit       = 1'b1;
                    emit_level = div_ovf ? fmsq_pkg::LEVEL_W'(fmsq_pkg::LEVEL_MAX) : div_quo;
                    emit_last  = cur_last_reg;
                    pop        = cur_last_reg;
                    state_next = cur_last_reg ? B_IDLE : B_START;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign valid_next = emit;

    fmsq_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (fmsq_pkg::LEVEL_W),
        .STEPS (fmsq_pkg::DIV_STEPS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            idx_reg      <= '0;
            cur_last_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cur_last_reg <= cur_last_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            level_reg  <= emit_level;
            origin_reg <= job.origin_centi;
            step_reg   <= job.step_size;
            frame_reg  <= job.frame_id;
            seq_reg    <= job.sequence_res;
            last_reg   <= emit_last;
        end
    end

    assign valid        = valid_reg;
    assign level        = level_reg;
    assign origin_centi = origin_reg;
    assign step_size    = step_reg;
    assign frame_id     = frame_reg;
    assign sequence_res = seq_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/frame_min_step_quantizer.sv
`default_nettype none
`include "frame_min_step_quantizer_defines.svh"

// Frame min/step quantizer. Pixels of a thermal frame are written one
// transaction at a time (start high while busy is low); after GRID_PIXELS
// pixels the block derives the frame origin (minimum floored to whole
// centi-degrees) and the step (span above the origin over 255, rounded up)
// and then plays back the whole frame as GRID_PIXELS result transactions in
// arrival order, each with its 8-bit level, the frame origin, step, frame
// number and sequence count, with last set on the final one. The receiver
// cannot stall: every result is present for exactly one cycle with valid
// high and must be captured then. After the final pixel, each of the two
// constant divisions that find origin and step is a reciprocal
// multiplication with a register stage behind it, followed by saturation or
// clamping, and busy is high while they run. Playback takes one pixel at a
// time: a pixel at or above the origin starts the divider, waits for it and
// takes its quotient, while a pixel below it skips the divider; at the start
// of a burst the block picks up the frame and reads its first pixel. The
// pixel store is double-buffered, so the next frame can be loaded while a
// burst plays out; busy also rises while two frames are queued, the one
// playing back and the next one.
module frame_min_step_quantizer #(
    parameter int GRID_PIXELS = fmsq_pkg::GRID_PIXELS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [fmsq_pkg::TEMP_W-1:0] temperature,
    input  wire logic [fmsq_pkg::FRAME_W-1:0]       frame_number,
    output logic                                    valid,
    output logic [fmsq_pkg::LEVEL_W-1:0]            level,
    output logic signed [fmsq_pkg::ORIGIN_W-1:0]    origin_centi,
    output logic [fmsq_pkg::STEP_W-1:0]             step_size,
    output logic [fmsq_pkg::FRAME_W-1:0]            frame_id,
    output logic [fmsq_pkg::SEQ_W-1:0]              sequence_res,
    output logic                                    last
);

    // One bank per frame in flight; the bank bit is the top address bit.
    localparam int IDX_W     = $clog2(GRID_PIXELS);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    fmsq_pkg::frame_job_t    push_job;
    fmsq_pkg::frame_job_t    head_job;
    fmsq_pkg::queue_status_t qstat;
    logic                    job_push;
    logic                    job_pop;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [fmsq_pkg::TEMP_W-1:0] ram_wdata;
    logic [fmsq_pkg::TEMP_W-1:0] ram_rdata;

    // The front loads pixels and computes the frame parameters. It hands a
    // frame descriptor to the queue once origin and step are known.
    fmsq_front #(
        .GRID_PIXELS (GRID_PIXELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .temperature  (temperature),
        .frame_number (frame_number),
        .qstat        (qstat),
        .push         (job_push),
        .job          (push_job),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata)
    );

    // The queue holds at most one descriptor per store bank, so a frame's
    // pixels are never overwritten before they have been played back.
    fmsq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head     (head_job),
        .status   (qstat)
    );

    // Pixel store: the front writes one bank while the back reads the other.
    fmsq_ram #(
        .WIDTH (fmsq_pkg::TEMP_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The back retires the head descriptor when it emits the final pixel.
    fmsq_back #(
        .GRID_PIXELS (GRID_PIXELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .job          (head_job),
        .pop          (job_pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .valid        (valid),
        .level        (level),
        .origin_centi (origin_centi),
        .step_size    (step_size),
        .frame_id     (frame_id),
        .sequence_res (sequence_res),
        .last         (last)
    );

    // A frame is only handed over when a bank is free for it.
    `FMSQ_ASSERT_NOW(a_push_not_full, clk, rst_n, job_push, !qstat.full, "frame pushed into full queue")
    // Playback only retires a frame that is actually queued.
    `FMSQ_ASSERT_NOW(a_pop_not_empty, clk, rst_n, job_pop, !qstat.empty, "pop from empty queue")
    // A pushed frame is visible to the back on the next cycle.
    `FMSQ_ASSERT_NEXT(a_push_fills, clk, rst_n, job_push, !qstat.empty, "queue empty after push")
    // The back always returns through its idle state between bursts.
    `FMSQ_ASSERT_NEXT(a_last_ends_burst, clk, rst_n, valid && last, !valid, "result right after last")

endmodule

`default_nettype wire
